@@ rtl/core/crcfs_pkg.sv @@
// ----------------------------------------------------------------------------
// crcfs_pkg
// Shared types, constants and the CRC-16/Modbus byte update for the frame
// synchronizing receiver.
// ----------------------------------------------------------------------------
package crcfs_pkg;

	localparam int BYTE_W      = 8;
	localparam int WORD_W      = 32;
	localparam int CRC_W       = 16;
	localparam int OUT_BYTES   = 12;

	localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
	localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CHECK
	} state_t;

	typedef struct packed {
		logic shift_in;
		logic rotate;
	} win_ctrl_t;

	typedef struct packed {
		logic init;
		logic step;
	} crc_ctrl_t;

	// One byte of reflected CRC-16/Modbus: eight dependent bit steps.
	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
			input logic [BYTE_W-1:0] data);
		logic [CRC_W-1:0] c;
		c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data};
		for (int b = 0; b < BYTE_W; b++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

@@ rtl/core/crc16_frame_sync_receiver_top.sv @@
// ----------------------------------------------------------------------------
// crc16_frame_sync_receiver_top
// Sliding-window frame synchronizer with a CRC-16/Modbus frame check.
// ----------------------------------------------------------------------------
// Usage:
// Received bytes enter on the rx channel (rx_valid, rx_ready, rx_byte), one
// item per byte. A byte that does not complete the window is just shifted in.
// A byte that completes it starts a scan: the window rotates once through
// the head tap while the CRC unit folds in one payload byte per cycle, then
// the compare step checks the sum against the two trailing bytes. rx_ready
// stays low through the scan and the compare step.
// On a match the three payload words are loaded into the output register
// and shown on the out channel (out_valid, out_ready, word_*); the window is
// emptied. On a mismatch the oldest byte is dropped on the next shift.
// A pending result does not block new bytes; only when a second match finds
// the output register still full does the block wait in the compare step
// until out_ready frees it.
// Reset empties the window and clears out_valid; the window contents need no
// clearing because bytes are read only once the window is full.
// ----------------------------------------------------------------------------
module crc16_frame_sync_receiver_top
	import crcfs_pkg::*;
#(
	parameter int FRAME_BYTES = 14
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rx_valid,
	output logic                rx_ready,
	input  logic [BYTE_W-1:0]   rx_byte,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [WORD_W-1:0]   word_first,
	output logic [WORD_W-1:0]   word_second,
	output logic [WORD_W-1:0]   word_third
);

	localparam int PAYLOAD_BYTES = FRAME_BYTES - 2;
	localparam int CNT_W         = $clog2(FRAME_BYTES + 1);

	state_t                      state_q, state_nx;
	logic [CNT_W-1:0]            fill_q;
	logic [CNT_W-1:0]            rot_q;
	logic                        out_valid_q;
	logic [WORD_W-1:0]           word_first_q, word_second_q, word_third_q;

	win_ctrl_t                   win_ctrl;
	crc_ctrl_t                   crc_ctrl;
	logic [BYTE_W-1:0]           win_head;
	logic [FRAME_BYTES*BYTE_W-1:0] win_flat;
	logic [CRC_W-1:0]            crc_val;

	logic                        rx_fire;
	logic                        fill_full;
	logic                        match;
	logic                        out_free;
	logic                        load_out;
	logic                        fill_clear;
	logic                        fill_drop;
	logic [CRC_W-1:0]            recv_crc;
	logic [OUT_BYTES*BYTE_W-1:0] payload;

	crcfs_window #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_window (
		.clk (clk),
		.ctrl(win_ctrl),
		.din (rx_byte),
		.head(win_head),
		.flat(win_flat)
	);

	crcfs_crc_unit u_crc (
		.clk (clk),
		.ctrl(crc_ctrl),
		.data(win_head),
		.crc (crc_val)
	);

	// The two trailing bytes hold the check value, low byte first.
	assign recv_crc  = win_flat[(FRAME_BYTES-2)*BYTE_W +: 2*BYTE_W];
	assign match     = (crc_val == recv_crc);
	assign fill_full = ((fill_q + CNT_W'(1)) == CNT_W'(FRAME_BYTES));
	assign rx_fire   = rx_valid && rx_ready;
	assign out_free  = !out_valid_q || out_ready;

	// Payload bytes past the end of a short frame read as zero.
	for (genvar k = 0; k < OUT_BYTES; k++) begin : g_payload
		if (k < PAYLOAD_BYTES) begin : g_byte
			assign payload[k*BYTE_W +: BYTE_W] = win_flat[k*BYTE_W +: BYTE_W];
		end else begin : g_zero
			assign payload[k*BYTE_W +: BYTE_W] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx            = state_q;
		rx_ready            = 1'b0;
		win_ctrl            = '0;
		crc_ctrl            = '0;
		load_out            = 1'b0;
		fill_clear          = 1'b0;
		fill_drop           = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				rx_ready          = 1'b1;
				win_ctrl.shift_in = rx_valid;
				if (rx_valid && fill_full) begin
					crc_ctrl.init = 1'b1;
					state_nx      = ST_SCAN;
				end
			end
			ST_SCAN: begin
				win_ctrl.rotate = 1'b1;
				crc_ctrl.step   = (rot_q < CNT_W'(PAYLOAD_BYTES));
				if (rot_q == CNT_W'(FRAME_BYTES - 1)) begin
					state_nx = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!match) begin
					fill_drop = 1'b1;
					state_nx  = ST_IDLE;
				end else if (out_free) begin
					load_out   = 1'b1;
					fill_clear = 1'b1;
					state_nx   = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else begin
			priority if (fill_clear) begin
				fill_q <= '0;
			end else if (fill_drop) begin
				fill_q <= CNT_W'(FRAME_BYTES - 1);
			end else if (rx_fire) begin
				fill_q <= fill_q + CNT_W'(1);
			end else begin
				// Hold.
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q <= '0;
		end else if (state_q == ST_SCAN) begin
			rot_q <= rot_q + CNT_W'(1);
		end else begin
			rot_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			word_first_q  <= payload[0*WORD_W +: WORD_W];
			word_second_q <= payload[1*WORD_W +: WORD_W];
			word_third_q  <= payload[2*WORD_W +: WORD_W];
		end
	end

	assign out_valid   = out_valid_q;
	assign word_first  = word_first_q;
	assign word_second = word_second_q;
	assign word_third  = word_third_q;

`ifndef NO_ASSERTIONS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(FRAME_BYTES))
		else $error("fill count exceeds the frame length");

	a_scan_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_CHECK) |-> fill_q == CNT_W'(FRAME_BYTES))
		else $error("scan running on a window that is not full");

	a_result_from_check: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_CHECK && match))
		else $error("result shown without a matching check");

	a_mismatch_slide: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK && !match) |=> fill_q == CNT_W'(FRAME_BYTES - 1))
		else $error("window did not slide after a mismatch");
`endif

endmodule

@@ rtl/core/crcfs_window.sv @@
// ----------------------------------------------------------------------------
// crcfs_window
// Byte window as a shift line. New bytes enter at the top end; during a scan
// the line rotates so that every byte passes the head tap once.
// ----------------------------------------------------------------------------
module crcfs_window
	import crcfs_pkg::*;
#(
	parameter int FRAME_BYTES = 14
) (
	input  logic                          clk,
	input  win_ctrl_t                     ctrl,
	input  logic [BYTE_W-1:0]             din,
	output logic [BYTE_W-1:0]             head,
	output logic [FRAME_BYTES*BYTE_W-1:0] flat
);

	logic [BYTE_W-1:0] win_q [FRAME_BYTES];

	always_ff @(posedge clk) begin
		priority if (ctrl.shift_in) begin
			for (int i = 0; i < FRAME_BYTES-1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[FRAME_BYTES-1] <= din;
		end else if (ctrl.rotate) begin
			for (int i = 0; i < FRAME_BYTES-1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[FRAME_BYTES-1] <= win_q[0];
		end else begin
			// Hold.
		end
	end

	assign head = win_q[0];

	always_comb begin
		for (int i = 0; i < FRAME_BYTES; i++) begin
			flat[i*BYTE_W +: BYTE_W] = win_q[i];
		end
	end

endmodule

@@ rtl/core/crcfs_crc_unit.sv @@
// ----------------------------------------------------------------------------
// crcfs_crc_unit
// Shared CRC-16/Modbus unit: folds one byte into the running remainder per
// step.
// ----------------------------------------------------------------------------
module crcfs_crc_unit
	import crcfs_pkg::*;
(
	input  logic              clk,
	input  crc_ctrl_t         ctrl,
	input  logic [BYTE_W-1:0] data,
	output logic [CRC_W-1:0]  crc
);

	logic [CRC_W-1:0] crc_q;

	always_ff @(posedge clk) begin
		priority if (ctrl.init) begin
			crc_q <= CRC_INIT;
		end else if (ctrl.step) begin
			crc_q <= crc_byte(crc_q, data);
		end else begin
			// Hold.
		end
	end

	assign crc = crc_q;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CRC-16/Modbus frame sync receiver testbench
// Feeds byte streams made of clean frames, damaged or cut frames and loose
// noise bytes. A scoreboard class tracks the sliding byte window itself and
// compares each payload result of the block against its own prediction.
// ----------------------------------------------------------------------------
module testbench;
	import crcfs_pkg::*;

	localparam int FRAME_LEN    = 14;
	localparam int ITEM_TARGET  = 1950;
	localparam int STALL_LIMIT  = 4000;
	localparam int HOLD_CYCLES  = 600;
	localparam int HOLD_AT      = 1400;
	localparam int DRAIN_CYCLES = 3 * (FRAME_LEN + 2);

	typedef struct packed {
		logic [WORD_W-1:0] first;
		logic [WORD_W-1:0] second;
		logic [WORD_W-1:0] third;
	} payload_t;

	// Mirrors the receive window and holds the payloads still to come out.
	class frame_tracker #(int FRAME_LEN = 14);
		logic [BYTE_W-1:0] window [FRAME_LEN];
		int fill;
		payload_t words_due[$];
		int mismatches;
		int frames_matched;

		function new();
			fill = 0;
			mismatches = 0;
			frames_matched = 0;
		endfunction

		static function logic [15:0] crc_fold(logic [15:0] c, logic [BYTE_W-1:0] d);
			logic [15:0] r;
			r = c ^ {8'h00, d};
			for (int k = 0; k < 8; k++) begin
				r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
			end
			return r;
		endfunction

		// Bytes beyond the payload read as zero.
		function logic [WORD_W-1:0] pack_word(int base);
			logic [WORD_W-1:0] w;
			w = '0;
			for (int k = 0; k < 4; k++) begin
				if (base + k < FRAME_LEN - 2) begin
					w[8*k +: 8] = window[base + k];
				end
			end
			return w;
		endfunction

		function void take_byte(logic [BYTE_W-1:0] b);
			logic [15:0] sum;
			payload_t p;
			if (fill < FRAME_LEN) begin
				window[fill] = b;
				fill++;
			end
			if (fill < FRAME_LEN) return;
			sum = 16'hFFFF;
			for (int i = 0; i < FRAME_LEN - 2; i++) begin
				sum = crc_fold(sum, window[i]);
			end
			if (sum == {window[FRAME_LEN-1], window[FRAME_LEN-2]}) begin
				p.first = pack_word(0);
				p.second = pack_word(4);
				p.third = pack_word(8);
				words_due = {words_due, p};
				fill = 0;
			end else begin
				for (int i = 0; i < FRAME_LEN - 1; i++) begin
					window[i] = window[i + 1];
				end
				window[FRAME_LEN-1] = '0;
				fill = FRAME_LEN - 1;
			end
		endfunction

		function void match_words(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b,
				logic [WORD_W-1:0] c);
			payload_t p;
			if (words_due.size() == 0) begin
				$display("%0t: result %h %h %h arrived with none expected", $time, a, b, c);
				mismatches++;
				return;
			end
			p = words_due[0];
			words_due.delete(0);
			frames_matched++;
			if (p.first !== a) begin
				$display("%0t: word_first expected %h, got %h", $time, p.first, a);
				mismatches++;
			end
			if (p.second !== b) begin
				$display("%0t: word_second expected %h, got %h", $time, p.second, b);
				mismatches++;
			end
			if (p.third !== c) begin
				$display("%0t: word_third expected %h, got %h", $time, p.third, c);
				mismatches++;
			end
		endfunction

		function int pending();
			return words_due.size();
		endfunction
	endclass

	typedef frame_tracker #(FRAME_LEN) tracker_t;

	logic              clk;
	logic              arst_n;
	logic              rx_valid;
	logic              rx_ready;
	logic [BYTE_W-1:0] rx_byte;
	logic              out_valid;
	logic              out_ready;
	logic [WORD_W-1:0] word_first;
	logic [WORD_W-1:0] word_second;
	logic [WORD_W-1:0] word_third;

	tracker_t tracker;
	int fed_count;
	int clean_frames;
	int damaged_frames;
	int noise_bytes;
	int quiet_cycles;
	int hold_left;
	bit hold_done;

	crc16_frame_sync_receiver_top #(
		.FRAME_BYTES(FRAME_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_ready(rx_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.word_first(word_first),
		.word_second(word_second),
		.word_third(word_third)
	);

	always #10 clk = ~clk;

	// Phase 0: sender idles 37%, receiver 64%; phase 1 the reverse; phase 2 none.
	function automatic int phase_of(int n);
		return (n < 650) ? 0 : (n < 1300) ? 1 : 2;
	endfunction

	function automatic int sender_idle_pct(int n);
		return (phase_of(n) == 0) ? 37 : (phase_of(n) == 1) ? 64 : 0;
	endfunction

	function automatic int receiver_idle_pct(int n);
		return (phase_of(n) == 0) ? 64 : (phase_of(n) == 1) ? 37 : 0;
	endfunction

	// Called and returns at a falling edge.
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		while ($urandom_range(99) < sender_idle_pct(fed_count)) begin
			rx_valid <= 1'b0;
			@(negedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!rx_ready);
		tracker.take_byte(b);
		fed_count++;
		@(negedge clk);
	endtask

	// fill_kind: 0 all zero payload, 1 all ones payload, other random payload.
	// A damaged frame either has one bit flipped or is cut short.
	task automatic send_frame(input int lead, input int fill_kind, input bit damage);
		logic [BYTE_W-1:0] frame_b [FRAME_LEN];
		logic [BYTE_W-1:0] v;
		logic [15:0] crc;
		int cut;
		crc = 16'hFFFF;
		for (int i = 0; i < lead; i++) begin
			send_byte(BYTE_W'($urandom_range(255)));
			noise_bytes++;
		end
		for (int i = 0; i < FRAME_LEN - 2; i++) begin
			v = (fill_kind == 0) ? 8'h00 : (fill_kind == 1) ? 8'hFF :
				BYTE_W'($urandom_range(255));
			frame_b[i] = v;
			crc = tracker.crc_fold(crc, v);
		end
		frame_b[FRAME_LEN-2] = crc[7:0];
		frame_b[FRAME_LEN-1] = crc[15:8];
		cut = FRAME_LEN;
		if (damage) begin
			damaged_frames++;
			if ($urandom_range(1)) begin
				frame_b[$urandom_range(FRAME_LEN - 1)][$urandom_range(7)] ^= 1'b1;
			end else begin
				cut = $urandom_range(3, FRAME_LEN - 1);
			end
		end else begin
			clean_frames++;
		end
		for (int i = 0; i < cut; i++) begin
			send_byte(frame_b[i]);
		end
	endtask

	task automatic wait_drained();
		rx_valid <= 1'b0;
		do @(negedge clk); while (tracker.pending() != 0);
	endtask

	// Receiver side: random stalls, plus one long hold-off in the no-idle phase
	// so the output register fills and the block has to stall its input.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (!hold_done && fed_count >= HOLD_AT) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= receiver_idle_pct(fed_count));
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			tracker.match_words(word_first, word_second, word_third);
		end
	end

	always @(posedge clk) begin
		if ((rx_valid && rx_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: timeout, no item moved for %0d cycles", $time, STALL_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int cur_phase;
		int pick;
		int kind;
		logic [BYTE_W-1:0] edge_bytes [9];
		clk = 1'b0;
		arst_n = 1'b0;
		rx_valid = 1'b0;
		rx_byte = '0;
		out_ready = 1'b0;
		fed_count = 0;
		clean_frames = 0;
		damaged_frames = 0;
		noise_bytes = 0;
		quiet_cycles = 0;
		hold_left = 0;
		hold_done = 1'b0;
		tracker = new();
		edge_bytes = '{8'hFF, 8'h00, 8'hAA, 8'h55, 8'h01, 8'h80, 8'hFE, 8'h7F, 8'h00};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: a leading stray byte forces one slide before an all-ones
		// frame locks, then loose extreme bytes start to refill the emptied window.
		send_byte(8'h00);
		noise_bytes++;
		send_frame(0, 1, 1'b0);
		foreach (edge_bytes[i]) begin
			send_byte(edge_bytes[i]);
			noise_bytes++;
		end

		cur_phase = phase_of(fed_count);
		while (fed_count < ITEM_TARGET) begin
			if (phase_of(fed_count) != cur_phase) begin
				wait_drained();
				cur_phase = phase_of(fed_count);
			end
			pick = $urandom_range(99);
			kind = $urandom_range(19);
			kind = (kind < 2) ? kind : 2;
			if (pick < 70) begin
				send_frame($urandom_range(1) ? 0 : $urandom_range(1, 3), kind, 1'b0);
			end else if (pick < 85) begin
				send_frame(0, kind, 1'b1);
			end else begin
				repeat ($urandom_range(1, 6)) begin
					send_byte(BYTE_W'($urandom_range(255)));
					noise_bytes++;
				end
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d bytes: %0d clean frames, %0d damaged or cut frames, %0d noise bytes.",
			fed_count, clean_frames, damaged_frames, noise_bytes);
		$display("Compared %0d payload results across idle mixes and a long output hold-off.",
			tracker.frames_matched);
		if (tracker.mismatches == 0 && tracker.pending() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

@@ crc16_frame_sync_receiver_top.f @@
rtl/core/crcfs_pkg.sv
rtl/core/crcfs_window.sv
rtl/core/crcfs_crc_unit.sv
rtl/core/crc16_frame_sync_receiver_top.sv
bench/testbench.sv
